@@ hdl/i2c_master_byte_sequencer_defines.svh @@
// Assertion macros used by the I2C byte sequencer RTL.
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, muted while reset is high.
`define I2CM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define I2CM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define I2CM_ASSERT(label, clk, rst, prop, msg)
`define I2CM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ hdl/i2cm_pkg.sv @@
// Types and constants of the I2C master byte sequencer.
package i2cm_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       with_start;
    logic       with_stop;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_received;
    logic       rejected;
  } res_t;

endpackage

@@ hdl/i2cm_cmd_if.sv @@
// Command channel: valid/ready handshake with the per-tick command fields.
interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       with_start;
  logic       with_stop;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, mode, data_byte, with_start, with_stop, send_ack, sda_in,
                  input ready);
  modport sink (input valid, mode, data_byte, with_start, with_stop, send_ack, sda_in,
                output ready);
endinterface

@@ hdl/i2cm_res_if.sv @@
// Result channel: valid/ready handshake with the bus levels and status.
interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_received;
  logic       rejected;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte,
                  ack_received, rejected, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_byte,
                ack_received, rejected, output ready);
endinterface

@@ hdl/i2c_master_byte_sequencer.sv @@
// I2C master byte sequencer top level: one command transfer in, one result transfer out.
// Each command transfer (a half-bit tick or a write, read or stop command) gives exactly
// one result transfer. A transfer can be taken every clock cycle while the result side
// accepts or the registers have room; each passes through the input register and then
// the result register, with the bus sequencer's next-state logic between them.
// Backpressure on the result side stalls the input only once both registers hold data.
module i2c_master_byte_sequencer (
  input logic      clk,
  input logic      rst,
  i2cm_cmd_if.sink   cmd,
  i2cm_res_if.source res
);
  import i2cm_pkg::*;

  cmd_t in_item;
  cmd_t stage_item;
  res_t res_next;
  res_t out_item;
  logic stage_valid;
  logic out_free;
  logic adv;

  assign in_item.mode       = cmd.mode;
  assign in_item.data_byte  = cmd.data_byte;
  assign in_item.with_start = cmd.with_start;
  assign in_item.with_stop  = cmd.with_stop;
  assign in_item.send_ack   = cmd.send_ack;
  assign in_item.sda_in     = cmd.sda_in;

  assign adv = stage_valid && out_free;

  i2cm_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .in_item     (in_item),
    .take        (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  i2cm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .step     (adv),
    .item     (stage_item),
    .res_next (res_next)
  );

  i2cm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .load_item (res_next),
    .free      (out_free),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_item  (out_item)
  );

  assign res.scl_out      = out_item.scl_out;
  assign res.sda_out      = out_item.sda_out;
  assign res.busy_res     = out_item.busy_res;
  assign res.done_res     = out_item.done_res;
  assign res.read_byte    = out_item.read_byte;
  assign res.ack_received = out_item.ack_received;
  assign res.rejected     = out_item.rejected;

endmodule

@@ hdl/i2cm_in_stage.sv @@
// Input register: captures one command transfer per cycle while it is empty or being taken.
module i2cm_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2cm_pkg::cmd_t in_item,
  input  logic          take,
  output logic          stage_valid,
  output i2cm_pkg::cmd_t stage_item
);
  import i2cm_pkg::*;

  logic valid;
  cmd_t item;

  assign in_ready    = !valid || take;
  assign stage_valid = valid;
  assign stage_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ hdl/i2cm_engine.sv @@
// Bus sequencer: state registers and the per-tick next-state and result logic.
`include "i2c_master_byte_sequencer_defines.svh"

module i2cm_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  i2cm_pkg::cmd_t item,
  output i2cm_pkg::res_t res_next
);
  import i2cm_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_BITS  = 3'd2,
    PH_ACK   = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] tick, tick_next;
  logic [3:0] bit_count, bit_count_next;
  logic [3:0] bit_count_inc;
  logic [7:0] shift_reg, shift_reg_next;
  logic       op_is_read, op_is_read_next;
  logic       stop_pending, stop_pending_next;
  logic       ack_bit_value, ack_bit_value_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       last_ack, last_ack_next;
  logic [7:0] rx_latch, rx_latch_next;
  logic       scl_o, sda_o, done, rej;

  assign bit_count_inc = bit_count + 4'd1;

  always_comb begin
    phase_next         = phase;
    tick_next          = tick;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    op_is_read_next    = op_is_read;
    stop_pending_next  = stop_pending;
    ack_bit_value_next = ack_bit_value;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    last_ack_next      = last_ack;
    rx_latch_next      = rx_latch;
    scl_o              = scl_level;
    sda_o              = sda_level;
    done               = 1'b0;
    rej                = 1'b0;

    if (item.mode != MODE_TICK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_next         = 2'd0;
        bit_count_next    = 4'd0;
        stop_pending_next = item.with_stop;
        case (item.mode)
          MODE_WRITE: begin
            op_is_read_next    = 1'b0;
            shift_reg_next     = item.data_byte;
            ack_bit_value_next = 1'b1;
            phase_next         = item.with_start ? PH_START : PH_BITS;
          end
          MODE_READ: begin
            op_is_read_next    = 1'b1;
            shift_reg_next     = 8'd0;
            ack_bit_value_next = !item.send_ack;
            phase_next         = PH_BITS;
          end
          default: begin
            op_is_read_next = 1'b0;
            phase_next      = PH_STOP;
          end
        endcase
      end
    end else begin
      unique case (phase)
        PH_START: begin
          scl_o = (tick != 2'd2);
          sda_o = (tick == 2'd0);
          scl_level_next = scl_o;
          sda_level_next = sda_o;
          if (tick >= 2'd2) begin
            phase_next     = PH_BITS;
            tick_next      = 2'd0;
            bit_count_next = 4'd0;
          end else begin
            tick_next = tick + 2'd1;
          end
        end
        PH_BITS: begin
          sda_o = op_is_read ? 1'b1 : shift_reg[7];
          scl_o = (tick != 2'd0);
          sda_level_next = sda_o;
          scl_level_next = 1'b0;
          if (tick == 2'd0) begin
            tick_next = 2'd1;
          end else begin
            tick_next      = 2'd0;
            shift_reg_next = {shift_reg[6:0], op_is_read & item.sda_in};
            bit_count_next = bit_count_inc;
            if (bit_count_inc >= BITS_PER_BYTE) begin
              if (op_is_read) begin
                rx_latch_next = shift_reg_next;
              end
              phase_next     = PH_ACK;
              bit_count_next = 4'd0;
            end
          end
        end
        PH_ACK: begin
          sda_o = op_is_read ? ack_bit_value : 1'b1;
          scl_o = (tick != 2'd0);
          sda_level_next = sda_o;
          scl_level_next = 1'b0;
          if (tick == 2'd0) begin
            tick_next = 2'd1;
          end else begin
            tick_next = 2'd0;
            if (!op_is_read) begin
              last_ack_next = !item.sda_in;
            end
            if (stop_pending) begin
              phase_next = PH_STOP;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
        end
        PH_STOP: begin
          scl_o = (tick == 2'd0) ? scl_level : 1'b1;
          sda_o = (tick >= 2'd2);
          scl_level_next = scl_o;
          sda_level_next = sda_o;
          if (tick >= 2'd2) begin
            phase_next        = PH_IDLE;
            tick_next         = 2'd0;
            stop_pending_next = 1'b0;
            done              = 1'b1;
          end else begin
            tick_next = tick + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end

    res_next.scl_out      = scl_o;
    res_next.sda_out      = sda_o;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.done_res     = done;
    res_next.read_byte    = rx_latch_next;
    res_next.ack_received = last_ack_next;
    res_next.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick          <= 2'd0;
      bit_count     <= 4'd0;
      shift_reg     <= 8'd0;
      op_is_read    <= 1'b0;
      stop_pending  <= 1'b0;
      ack_bit_value <= 1'b1;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      last_ack      <= 1'b0;
      rx_latch      <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      tick          <= tick_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      op_is_read    <= op_is_read_next;
      stop_pending  <= stop_pending_next;
      ack_bit_value <= ack_bit_value_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      last_ack      <= last_ack_next;
      rx_latch      <= rx_latch_next;
    end
  end

  `I2CM_ASSERT(a_reject_only_busy, clk, rst, (step && rej) |-> (phase != PH_IDLE), "reject while idle")
  `I2CM_ASSERT(a_done_to_idle, clk, rst, (step && done) |=> (phase == PH_IDLE), "done without idle")
  `I2CM_ASSERT(a_tick_range, clk, rst, tick != 2'd3, "tick out of range")
  `I2CM_ASSERT(a_bit_count_range, clk, rst, bit_count < BITS_PER_BYTE, "bit count overrun")

endmodule

@@ hdl/i2cm_out_stage.sv @@
// Result register: holds one result until the sink takes it.
module i2cm_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  i2cm_pkg::res_t load_item,
  output logic           free,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::res_t out_item
);
  import i2cm_pkg::*;

  logic valid;
  res_t item;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
    if (load) begin
      item <= load_item;
    end
  end

endmodule

@@ verif/i2c_master_byte_sequencer_tb.sv @@
// Self-checking testbench of the I2C master byte sequencer: command/tick stream vs bus model.
`timescale 1ns / 100ps

module i2c_master_byte_sequencer_tb;
  import i2cm_pkg::*;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_BITS,
    SEQ_ACK,
    SEQ_STOP
  } seq_phase_t;

  logic clk;
  logic rst;

  i2cm_cmd_if cmd_bus ();
  i2cm_res_if res_bus ();

  i2c_master_byte_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  // bus model state
  seq_phase_t seq_phase     = SEQ_IDLE;
  logic [1:0] seq_tick      = '0;
  logic [3:0] seq_bits      = '0;
  logic [7:0] seq_shift     = '0;
  logic       seq_read      = 1'b0;
  logic       seq_stop_pend = 1'b0;
  logic       seq_ack_level = 1'b1;
  logic       held_scl      = 1'b1;
  logic       held_sda      = 1'b1;
  logic       slave_ack     = 1'b0;
  logic [7:0] rx_byte       = '0;

  res_t bus_snapshots_due[$];

  int errors    = 0;
  int n_items   = 0;
  int n_writes  = 0;
  int n_reads   = 0;
  int n_stops   = 0;
  int n_rejects = 0;
  int n_done    = 0;
  int n_checked = 0;
  int burst_left = 0;

  int         stall_style = 0;
  int         style_left  = 0;
  logic [7:0] stall_mask  = 8'hff;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("%0t: timeout, %0d results outstanding", $time, bus_snapshots_due.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic res_t sequencer_step(cmd_t c);
    res_t r;
    r = '0;
    r.scl_out = held_scl;
    r.sda_out = held_sda;
    if (c.mode != MODE_TICK) begin
      if (seq_phase != SEQ_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        seq_tick = '0;
        seq_bits = '0;
        seq_stop_pend = c.with_stop;
        case (c.mode)
          MODE_WRITE: begin
            seq_read = 1'b0;
            seq_shift = c.data_byte;
            seq_ack_level = 1'b1;
            seq_phase = c.with_start ? SEQ_START : SEQ_BITS;
          end
          MODE_READ: begin
            seq_read = 1'b1;
            seq_shift = '0;
            seq_ack_level = ~c.send_ack;
            seq_phase = SEQ_BITS;
          end
          default: begin
            seq_read = 1'b0;
            seq_phase = SEQ_STOP;
          end
        endcase
      end
    end else begin
      case (seq_phase)
        SEQ_START: begin
          case (seq_tick)
            2'd0: {r.scl_out, r.sda_out} = 2'b11;
            2'd1: {r.scl_out, r.sda_out} = 2'b10;
            default: {r.scl_out, r.sda_out} = 2'b00;
          endcase
          held_scl = r.scl_out;
          held_sda = r.sda_out;
          if (seq_tick >= 2'd2) begin
            seq_phase = SEQ_BITS;
            seq_tick = '0;
            seq_bits = '0;
          end else begin
            seq_tick = seq_tick + 2'd1;
          end
        end
        SEQ_BITS: begin
          r.sda_out = seq_read ? 1'b1 : seq_shift[7];
          r.scl_out = (seq_tick != 2'd0);
          held_sda = r.sda_out;
          held_scl = 1'b0;
          if (seq_tick == 2'd0) begin
            seq_tick = 2'd1;
          end else begin
            seq_tick = '0;
            seq_shift = {seq_shift[6:0], seq_read ? c.sda_in : 1'b0};
            seq_bits = seq_bits + 4'd1;
            if (seq_bits >= BITS_PER_BYTE) begin
              if (seq_read) rx_byte = seq_shift;
              seq_phase = SEQ_ACK;
              seq_bits = '0;
            end
          end
        end
        SEQ_ACK: begin
          r.sda_out = seq_read ? seq_ack_level : 1'b1;
          r.scl_out = (seq_tick != 2'd0);
          held_sda = r.sda_out;
          held_scl = 1'b0;
          if (seq_tick == 2'd0) begin
            seq_tick = 2'd1;
          end else begin
            seq_tick = '0;
            if (!seq_read) slave_ack = ~c.sda_in;
            if (seq_stop_pend) begin
              seq_phase = SEQ_STOP;
            end else begin
              seq_phase = SEQ_IDLE;
              r.done_res = 1'b1;
            end
          end
        end
        SEQ_STOP: begin
          case (seq_tick)
            2'd0: {r.scl_out, r.sda_out} = {held_scl, 1'b0};
            2'd1: {r.scl_out, r.sda_out} = 2'b10;
            default: {r.scl_out, r.sda_out} = 2'b11;
          endcase
          held_scl = r.scl_out;
          held_sda = r.sda_out;
          if (seq_tick >= 2'd2) begin
            seq_phase = SEQ_IDLE;
            seq_tick = '0;
            seq_stop_pend = 1'b0;
            r.done_res = 1'b1;
          end else begin
            seq_tick = seq_tick + 2'd1;
          end
        end
        default: ;
      endcase
    end
    r.busy_res = (seq_phase != SEQ_IDLE);
    r.read_byte = rx_byte;
    r.ack_received = slave_ack;
    return r;
  endfunction

  function automatic cmd_t random_cmd(logic [1:0] m);
    cmd_t c;
    c.mode = m;
    c.data_byte = 8'($urandom_range(0, 255));
    c.with_start = 1'($urandom_range(0, 1));
    c.with_stop = 1'($urandom_range(0, 1));
    c.send_ack = 1'($urandom_range(0, 1));
    c.sda_in = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(cmd_t c);
    res_t r;
    cmd_bus.valid = 1'b1;
    cmd_bus.mode = c.mode;
    cmd_bus.data_byte = c.data_byte;
    cmd_bus.with_start = c.with_start;
    cmd_bus.with_stop = c.with_stop;
    cmd_bus.send_ack = c.send_ack;
    cmd_bus.sda_in = c.sda_in;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    r = sequencer_step(c);
    bus_snapshots_due.push_back(r);
    n_items++;
    if (r.rejected) n_rejects++;
    else if (c.mode == MODE_WRITE) n_writes++;
    else if (c.mode == MODE_READ) n_reads++;
    else if (c.mode == MODE_STOP) n_stops++;
    if (r.done_res) n_done++;
    @(negedge clk);
    cmd_bus.valid = 1'b0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_drained();
    int spins;
    cmd_bus.valid = 1'b0;
    spins = 0;
    while (bus_snapshots_due.size() != 0 && spins < 4000) begin
      @(posedge clk);
      spins++;
    end
    if (bus_snapshots_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, bus_snapshots_due.size());
    end
    repeat (4) @(negedge clk);
  endtask

  // command, then ticks until the sequencer goes idle; some commands land while busy
  task automatic run_transaction(cmd_t c, int reject_pct);
    cmd_t t;
    send_cmd(c);
    while (seq_phase != SEQ_IDLE) begin
      if ($urandom_range(0, 99) < reject_pct) t = random_cmd(2'($urandom_range(1, 3)));
      else t = random_cmd(MODE_TICK);
      send_cmd(t);
    end
  endtask

  task automatic test_idle_ticks();
    cmd_t c;
    c = '{mode: MODE_TICK, data_byte: 8'hff, with_start: 1'b1, with_stop: 1'b1,
          send_ack: 1'b1, sda_in: 1'b0};
    send_cmd(c);
    c = '{mode: MODE_TICK, data_byte: 8'h00, with_start: 1'b0, with_stop: 1'b0,
          send_ack: 1'b0, sda_in: 1'b1};
    send_cmd(c);
  endtask

  task automatic test_stop_only();
    cmd_t c;
    c = random_cmd(MODE_STOP);
    run_transaction(c, 0);
  endtask

  task automatic test_write_with_start_and_reject();
    cmd_t c;
    c = '{mode: MODE_WRITE, data_byte: 8'hff, with_start: 1'b1, with_stop: 1'b0,
          send_ack: 1'b0, sda_in: 1'b1};
    send_cmd(c);
    repeat (3) send_cmd(random_cmd(MODE_TICK));
    send_cmd(random_cmd(MODE_READ));
    c = random_cmd(MODE_TICK);
    c.sda_in = 1'b0;
    while (seq_phase != SEQ_IDLE) send_cmd(c);
  endtask

  task automatic test_random_transactions(int target);
    int first;
    int pick;
    cmd_t c;
    first = n_items;
    wait_drained();
    while (n_items - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) c = random_cmd(MODE_WRITE);
      else if (pick < 85) c = random_cmd(MODE_READ);
      else c = random_cmd(MODE_STOP);
      if ($urandom_range(0, 9) == 0) send_cmd(random_cmd(MODE_TICK));
      run_transaction(c, 5);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  task automatic test_random_noise(int target);
    int first;
    first = n_items;
    while (n_items - first < target) begin
      if ($urandom_range(0, 9) < 7) send_cmd(random_cmd(MODE_TICK));
      else send_cmd(random_cmd(2'($urandom_range(1, 3))));
    end
  endtask

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (bus_snapshots_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none, actual scl %b sda %b",
                 $time, res_bus.scl_out, res_bus.sda_out);
      end else begin
        res_t want;
        want = bus_snapshots_due.pop_front();
        n_checked++;
        check_field("scl_out", 8'(want.scl_out), 8'(res_bus.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(res_bus.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(res_bus.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(res_bus.done_res));
        check_field("read_byte", want.read_byte, res_bus.read_byte);
        check_field("ack_received", 8'(want.ack_received), 8'(res_bus.ack_received));
        check_field("rejected", 8'(want.rejected), 8'(res_bus.rejected));
      end
    end
  end

  // receiver: always ready, random stalls, or a rotating stall mask
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left = $urandom_range(32, 256);
      stall_mask = 8'($urandom_range(0, 255)) | 8'h01;
    end else begin
      style_left--;
    end
    case (stall_style)
      0: res_bus.ready = 1'b1;
      1: res_bus.ready = ($urandom_range(0, 2) != 0);
      default: begin
        res_bus.ready = stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[7:1]};
      end
    endcase
  end

  initial begin
    rst = 1'b1;
    cmd_bus.valid = 1'b0;
    cmd_bus.mode = MODE_TICK;
    cmd_bus.data_byte = '0;
    cmd_bus.with_start = 1'b0;
    cmd_bus.with_stop = 1'b0;
    cmd_bus.send_ack = 1'b0;
    cmd_bus.sda_in = 1'b0;
    res_bus.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_ticks();
    test_stop_only();
    test_write_with_start_and_reject();
    test_random_transactions(550);
    test_random_noise(150);
    wait_drained();

    $display("%0d transfers checked: %0d writes, %0d reads, %0d stops accepted, %0d rejected",
             n_checked, n_writes, n_reads, n_stops, n_rejects);
    $display("%0d operations completed, %0d errors", n_done, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
